[hdl/urk3_pkg.sv]
// ----------------------------------------------------------------------------
// urk3_pkg: shared constants and helpers for the unicycle RK3 state step
// Number formats, CORDIC arctangent table and small rounding helpers.
// ----------------------------------------------------------------------------
package urk3_pkg;

  localparam int TRIG_ITERATIONS_DEF = 16;
  localparam int CORDIC_TABLE_LEN    = 24;

  localparam logic signed [17:0] PI_Q13      = 18'sd25736;
  localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

  localparam logic [15:0] TIME_STEP_RST   = 16'd6554;
  localparam logic [15:0] SPEED_LIMIT_RST = 16'd768;

  localparam logic REG_TIME_STEP   = 1'b0;
  localparam logic REG_SPEED_LIMIT = 1'b1;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] r;
    r = 34'sd0;
    case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = (i < CORDIC_TABLE_LEN) ? (34'sd1 <<< (30 - i)) : 34'sd0;
    endcase
    return r;
  endfunction

  // Wrap a heading that lies within three pi of the range to [-pi, pi).
  function automatic logic signed [15:0] wrap_heading(input logic signed [17:0] h);
    logic signed [17:0] t;
    t = h;
    if (t >= PI_Q13) t = t - TWO_PI_Q13;
    else if (t < -PI_Q13) t = t + TWO_PI_Q13;
    if (t >= PI_Q13) t = t - TWO_PI_Q13;
    else if (t < -PI_Q13) t = t + TWO_PI_Q13;
    return t[15:0];
  endfunction

  // Signed divide by 2^n, rounding to nearest with ties away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                  input int n);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    q = (mag + (64'd1 << (n - 1))) >> n;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

endpackage

[hdl/urk3_cordic.sv]
// ----------------------------------------------------------------------------
// urk3_cordic: pipelined sin/cos followed by velocity scaling
// One CORDIC iteration per register stage; three angles rotate side by side.
// ----------------------------------------------------------------------------
module urk3_cordic #(
  parameter int ITERS = urk3_pkg::TRIG_ITERATIONS_DEF,
  parameter int SW    = 160
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [2:0][15:0]  ang,
  input  logic signed [2:0][16:0]  spd,
  input  logic [SW-1:0]            side_in,
  output logic signed [2:0][33:0]  vx,
  output logic signed [2:0][33:0]  vy,
  output logic [SW-1:0]            side_out
);

  logic signed [2:0][33:0] cx [0:ITERS];
  logic signed [2:0][33:0] cy [0:ITERS];
  logic signed [2:0][33:0] cz [0:ITERS];
  logic        [2:0]       ng [0:ITERS];
  logic signed [2:0][16:0] sp [0:ITERS];
  logic [SW-1:0]           sd [0:ITERS];
  logic signed [2:0][33:0] cx0, cy0, cz0;
  logic        [2:0]       ng0;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [17:0] a;
      a = 18'($signed(ang[k]));
      ng0[k] = 1'b0;
      if (a > urk3_pkg::HALF_PI_Q13) begin
        a = a - urk3_pkg::PI_Q13;
        ng0[k] = 1'b1;
      end else if (a < -urk3_pkg::HALF_PI_Q13) begin
        a = a + urk3_pkg::PI_Q13;
        ng0[k] = 1'b1;
      end
      cz0[k] = 34'(a) <<< 17;
      cx0[k] = urk3_pkg::CORDIC_START;
      cy0[k] = 34'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= cx0;
      cy[0] <= cy0;
      cz[0] <= cz0;
      ng[0] <= ng0;
      sp[0] <= spd;
      sd[0] <= side_in;
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    logic signed [2:0][33:0] nx, ny, nz;
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        logic signed [33:0] x, y, z, dx, dy;
        x = cx[i][k];
        y = cy[i][k];
        z = cz[i][k];
        dx = y >>> i;
        dy = x >>> i;
        if (!z[33]) begin
          nx[k] = x - dx;
          ny[k] = y + dy;
          nz[k] = z - urk3_pkg::atan_q30(i);
        end else begin
          nx[k] = x + dx;
          ny[k] = y - dy;
          nz[k] = z + urk3_pkg::atan_q30(i);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cx[i+1] <= nx;
        cy[i+1] <= ny;
        cz[i+1] <= nz;
        ng[i+1] <= ng[i];
        sp[i+1] <= sp[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  // Speed times cos/sin, rounded from Q10.38 down to Q10.16.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [33:0] c, s;
        logic signed [16:0] v;
        c = ng[ITERS][k] ? -cx[ITERS][k] : cx[ITERS][k];
        s = ng[ITERS][k] ? -cy[ITERS][k] : cy[ITERS][k];
        v = sp[ITERS][k];
        vx[k] <= 34'(urk3_pkg::rnd_shift(64'(v) * 64'(c), 22));
        vy[k] <= 34'(urk3_pkg::rnd_shift(64'(v) * 64'(s), 22));
      end
      side_out <= sd[ITERS];
    end
  end

endmodule

[hdl/unicycle_rk3_state_step.sv]
// ----------------------------------------------------------------------------
// unicycle_rk3_state_step: one RK3 step of a fixed-point unicycle model
//
//  channel   handshake              beat contents
//  in        in_valid / in_ready    pos_x pos_y heading_in speed_in progress_in
//                                   accel_cmd turn_rate_cmd
//  out       out_valid / out_ready  next_x next_y next_heading next_speed
//                                   next_progress
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (0 time step, 1 limit)
//
// One beat is accepted per cycle unless the output stalls. There are two stages
// ahead of the CORDIC, TRIG_ITERATIONS + 2 inside it with one rotation per
// stage, and four behind it for the weighted sums and the divide by six.
// The whole pipeline advances together when the output register is empty or
// being emptied; a stalled output freezes every stage, so nothing is lost.
// Reset clears valid bits and restores time_step 6554 and speed_limit 768.
// ----------------------------------------------------------------------------
module unicycle_rk3_state_step #(
  parameter int TRIG_ITERATIONS = urk3_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] heading_in,
  input  logic signed [15:0] speed_in,
  input  logic        [31:0] progress_in,
  input  logic signed [15:0] accel_cmd,
  input  logic signed [15:0] turn_rate_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] next_x,
  output logic signed [31:0] next_y,
  output logic signed [15:0] next_heading,
  output logic        [15:0] next_speed,
  output logic        [31:0] next_progress,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic        [15:0] cfg_data
);

  localparam int DEPTH = TRIG_ITERATIONS + 8;
  // Side data carried beside the CORDIC: x, y, progress, psi3, v3, p1, v2.
  localparam int SW = 32 + 32 + 32 + 16 + 16 + 16 + 16;
  // ceil(2^33 / 3); exact floor division by three for any 32-bit value.
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  logic [15:0] time_step, speed_limit;
  logic [DEPTH-1:0] vld;
  logic en;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= urk3_pkg::TIME_STEP_RST;
      speed_limit <= urk3_pkg::SPEED_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        urk3_pkg::REG_TIME_STEP:   time_step   <= cfg_data;
        urk3_pkg::REG_SPEED_LIMIT: speed_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole chain moves when the last stage is empty or being taken.
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // Stage A: capture the beat, wrap the heading and form dt*omega and dt*a products.
  logic signed [31:0] a_x, a_y;
  logic        [31:0] a_p;
  logic signed [15:0] a_psi, a_v;
  logic signed [33:0] a_dom, a_dacc;
  always_ff @(posedge clk) begin
    if (en) begin
      a_x    <= pos_x;
      a_y    <= pos_y;
      a_p    <= progress_in;
      a_psi  <= urk3_pkg::wrap_heading(18'(heading_in));
      a_v    <= speed_in;
      a_dom  <= $signed({1'b0, time_step}) * 34'(turn_rate_cmd);
      a_dacc <= $signed({1'b0, time_step}) * 34'(accel_cmd);
    end
  end

  // Stage B: stage-2 and stage-3 headings and speeds. The clamped speeds can
  // reach 65535 with a wide limit, so they are kept unsigned.
  logic signed [31:0] b_x, b_y;
  logic        [31:0] b_p;
  logic signed [15:0] b_psi, b_v, b_psi2, b_psi3;
  logic        [15:0] b_v2, b_v3;
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [17:0] s2, s3;
      logic signed [19:0] u2, u3;
      s2 = 18'(a_psi) + 18'(urk3_pkg::rnd_shift(64'(a_dom), 17));
      s3 = 18'(a_psi) + 18'(urk3_pkg::rnd_shift(64'(a_dom), 16));
      u2 = 20'(a_v) + 20'(urk3_pkg::rnd_shift(64'(a_dacc), 17));
      u3 = 20'(a_v) + 20'(urk3_pkg::rnd_shift(64'(a_dacc), 16));
      b_psi2 <= urk3_pkg::wrap_heading(s2);
      b_psi3 <= urk3_pkg::wrap_heading(s3);
      b_v2 <= u2[19] ? 16'd0 : (u2 > $signed({4'd0, speed_limit}))
              ? speed_limit : u2[15:0];
      b_v3 <= u3[19] ? 16'd0 : (u3 > $signed({4'd0, speed_limit}))
              ? speed_limit : u3[15:0];
      b_x <= a_x;
      b_y <= a_y;
      b_p <= a_p;
      b_psi <= a_psi;
      b_v <= a_v;
    end
  end

  logic [15:0] b_p1;
  assign b_p1 = b_v[15] ? 16'd0 : b_v;

  logic signed [2:0][33:0] vx, vy;
  logic [SW-1:0] c_side;
  urk3_cordic #(.ITERS(TRIG_ITERATIONS), .SW(SW)) u_cordic (
    .clk     (clk),
    .en      (en),
    .ang     ({b_psi3, b_psi2, b_psi}),
    .spd     ({{1'b0, b_v3}, {1'b0, b_v2}, {b_v[15], b_v}}),
    .side_in ({b_x, b_y, b_p, b_psi3, b_v3, b_p1, b_v2}),
    .vx      (vx),
    .vy      (vy),
    .side_out(c_side)
  );

  logic signed [31:0] c_x, c_y;
  logic        [31:0] c_p;
  logic signed [15:0] c_psi3;
  logic        [15:0] c_v3, c_p1, c_v2;
  assign {c_x, c_y, c_p, c_psi3, c_v3, c_p1, c_v2} = c_side;

  // Stage D: weighted sums times dt.
  logic signed [31:0] d_x, d_y;
  logic        [31:0] d_p;
  logic signed [15:0] d_psi3;
  logic        [15:0] d_v3;
  logic signed [54:0] d_mx, d_my;
  logic signed [37:0] d_mp;
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [37:0] sx, sy;
      logic signed [20:0] sp;
      sx = 38'($signed(vx[0])) + (38'($signed(vx[1])) <<< 2) + 38'($signed(vx[2]));
      sy = 38'($signed(vy[0])) + (38'($signed(vy[1])) <<< 2) + 38'($signed(vy[2]));
      sp = 21'(c_p1) + (21'(c_v2) <<< 2) + 21'(c_v3);
      d_mx <= 55'(sx) * $signed({39'd0, time_step});
      d_my <= 55'(sy) * $signed({39'd0, time_step});
      d_mp <= 38'(sp) * $signed({22'd0, time_step});
      d_x <= c_x;
      d_y <= c_y;
      d_p <= c_p;
      d_psi3 <= c_psi3;
      d_v3 <= c_v3;
    end
  end

  // Stage E: take magnitudes, add half the divisor, and drop the power-of-two
  // part of six times the scale. Only a divide by three is left.
  logic signed [31:0] e_x, e_y;
  logic        [31:0] e_p;
  logic signed [15:0] e_psi3;
  logic        [15:0] e_v3;
  logic               e_nx, e_ny;
  logic        [31:0] e_qx, e_qy, e_qp;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [54:0] mx, my;
      logic [37:0] mp;
      mx = (d_mx[54] ? 55'(-d_mx) : 55'(d_mx)) + 55'(3 << 16);
      my = (d_my[54] ? 55'(-d_my) : 55'(d_my)) + 55'(3 << 16);
      mp = 38'(d_mp) + 38'(3 << 8);
      e_qx <= 32'(mx >> 17);
      e_qy <= 32'(my >> 17);
      e_qp <= 32'(mp >> 9);
      e_nx <= d_mx[54];
      e_ny <= d_my[54];
      e_x <= d_x;
      e_y <= d_y;
      e_p <= d_p;
      e_psi3 <= d_psi3;
      e_v3 <= d_v3;
    end
  end

  // Stage F: divide by three with a reciprocal multiply.
  logic signed [31:0] f_x, f_y;
  logic        [31:0] f_p;
  logic signed [15:0] f_psi3;
  logic        [15:0] f_v3;
  logic               f_nx, f_ny;
  logic        [63:0] f_px, f_py, f_pp;
  always_ff @(posedge clk) begin
    if (en) begin
      f_px <= 64'(e_qx) * 64'(RECIP3);
      f_py <= 64'(e_qy) * 64'(RECIP3);
      f_pp <= 64'(e_qp) * 64'(RECIP3);
      f_nx <= e_nx;
      f_ny <= e_ny;
      f_x <= e_x;
      f_y <= e_y;
      f_p <= e_p;
      f_psi3 <= e_psi3;
      f_v3 <= e_v3;
    end
  end

  // Stage G: restore the sign, add to the old state and saturate.
  always_ff @(posedge clk) begin
    if (en) begin
      logic [31:0] qx, qy, qp;
      logic signed [33:0] tx, ty;
      logic [32:0] tp;
      qx = 32'(f_px >> 33);
      qy = 32'(f_py >> 33);
      qp = 32'(f_pp >> 33);
      tx = 34'(f_x) + (f_nx ? -$signed({2'b0, qx}) : $signed({2'b0, qx}));
      ty = 34'(f_y) + (f_ny ? -$signed({2'b0, qy}) : $signed({2'b0, qy}));
      tp = {1'b0, f_p} + {1'b0, qp};
      next_x <= (tx > 34'sd2147483647) ? 32'sh7FFFFFFF :
                (tx < -34'sd2147483648) ? 32'sh80000000 : tx[31:0];
      next_y <= (ty > 34'sd2147483647) ? 32'sh7FFFFFFF :
                (ty < -34'sd2147483648) ? 32'sh80000000 : ty[31:0];
      next_progress <= tp[32] ? 32'hFFFFFFFF : tp[31:0];
      next_heading <= f_psi3;
      next_speed <= f_v3;
    end
  end

endmodule

[bench/unicycle_rk3_state_step_test.sv]
// ----------------------------------------------------------------------------
// unicycle_rk3_state_step_test: self-checking bench for the RK3 unicycle step
// Drives state and control beats with random gaps, predicts every step with
// an independent fixed-point model and compares each output beat field by
// field. Both configuration registers are swept across several settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module unicycle_rk3_state_step_test;

  localparam int TRIG_STEPS = 16;
  localparam int LATENCY    = TRIG_STEPS + 8;
  localparam longint CYCLE_LIMIT = 400000;

  // One vehicle state plus control pair, as carried by an input beat.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] hdg;
    logic signed [15:0] spd;
    logic        [31:0] prog;
    logic signed [15:0] acc;
    logic signed [15:0] turn;
  } vehicle_t;

  // The advanced state, as carried by an output beat.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] hdg;
    logic        [15:0] spd;
    logic        [31:0] prog;
  } advanced_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [15:0] heading_in = '0;
  logic signed [15:0] speed_in = '0;
  logic        [31:0] progress_in = '0;
  logic signed [15:0] accel_cmd = '0;
  logic signed [15:0] turn_rate_cmd = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] next_x;
  logic signed [31:0] next_y;
  logic signed [15:0] next_heading;
  logic        [15:0] next_speed;
  logic        [31:0] next_progress;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = urk3_pkg::REG_TIME_STEP;
  logic [15:0] cfg_data = '0;

  unicycle_rk3_state_step #(.TRIG_ITERATIONS(TRIG_STEPS)) u_dut (.*);

  always #5 clk = ~clk;

  // Our copy of the two configuration registers.
  longint step_dt;
  longint speed_cap;

  advanced_t pending_steps[$];
  bit     failed = 1'b0;
  longint cycles = 0;
  int     drain_stall_max = 12;

  // Arctangent table in Q2.30, written out independently of the package.
  longint atan_tab[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                           33543516, 16775851, 8388437, 4194283, 2097149,
                           1048576, 524288, 262144, 131072, 65536, 32768};

  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint wrap_angle(longint h);
    longint t;
    t = (h + 25736) % 51472;
    if (t < 0) t += 51472;
    return t - 25736;
  endfunction

  function automatic longint limit_speed(longint v);
    if (v < 0) return 0;
    if (v > speed_cap) return speed_cap;
    return v;
  endfunction

  // CORDIC rotation giving cos and sin in Q2.30 for a Q3.13 angle.
  task automatic rotate_unit(input longint ang, output longint c, output longint s);
    longint cx, cy, z, dx, dy;
    bit flip;
    flip = 1'b0;
    cx = 652032874;
    cy = 0;
    if (ang > 12868) begin
      ang -= 25736; flip = 1'b1;
    end else if (ang < -12868) begin
      ang += 25736; flip = 1'b1;
    end
    z = ang * 131072;
    for (int i = 0; i < TRIG_STEPS; i++) begin
      dx = floor_shift(cy, i);
      dy = floor_shift(cx, i);
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= atan_tab[i];
      end else begin
        cx += dx; cy -= dy; z += atan_tab[i];
      end
    end
    c = flip ? -cx : cx;
    s = flip ? -cy : cy;
  endtask

  task automatic velocity(input longint psi, input longint v,
                          output longint vx, output longint vy);
    longint c, s;
    rotate_unit(psi, c, s);
    vx = round_div(v * c, 64'd1 << 22);
    vy = round_div(v * s, 64'd1 << 22);
  endtask

  function automatic longint clip_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Full RK3 step: three stage derivatives, weighted 1:4:1.
  task automatic advance_vehicle(input vehicle_t s, output advanced_t r);
    longint psi, v, a, om, k1x, k1y, k2x, k2y, k3x, k3y;
    longint psi2, psi3, v2, v3, p1, np;
    psi = wrap_angle(longint'(s.hdg));
    v = s.spd;
    a = s.acc;
    om = s.turn;
    velocity(psi, v, k1x, k1y);
    p1 = (v > 0) ? v : 0;
    psi2 = wrap_angle(psi + round_div(step_dt * om, 64'd1 << 17));
    v2 = limit_speed(v + round_div(step_dt * a, 64'd1 << 17));
    velocity(psi2, v2, k2x, k2y);
    psi3 = wrap_angle(psi + round_div(step_dt * om, 64'd1 << 16));
    v3 = limit_speed(v + round_div(step_dt * a, 64'd1 << 16));
    velocity(psi3, v3, k3x, k3y);
    r.x = 32'(clip_s32(longint'(s.x) +
                       round_div(step_dt * (k1x + 4 * k2x + k3x), 6 << 16)));
    r.y = 32'(clip_s32(longint'(s.y) +
                       round_div(step_dt * (k1y + 4 * k2y + k3y), 6 << 16)));
    np = longint'({32'd0, s.prog}) + round_div(step_dt * (p1 + 4 * v2 + v3), 6 << 8);
    if (np > 64'hFFFF_FFFF) np = 64'hFFFF_FFFF;
    r.prog = np[31:0];
    r.hdg = psi3[15:0];
    r.spd = v3[15:0];
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output side: random stalls, and every beat checked against the oldest
  // predicted step.
  initial begin
    int wait_n;
    advanced_t want;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      wait_n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, drain_stall_max);
      if (wait_n != 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_steps.size() == 0) begin
        $error("output beat with no step outstanding");
        failed = 1'b1;
      end else begin
        want = pending_steps.pop_front();
        if (next_x !== want.x) begin
          $error("next_x expected %0d actual %0d", want.x, next_x); failed = 1'b1;
        end
        if (next_y !== want.y) begin
          $error("next_y expected %0d actual %0d", want.y, next_y); failed = 1'b1;
        end
        if (next_heading !== want.hdg) begin
          $error("next_heading expected %0d actual %0d", want.hdg, next_heading);
          failed = 1'b1;
        end
        if (next_speed !== want.spd) begin
          $error("next_speed expected %0d actual %0d", want.spd, next_speed);
          failed = 1'b1;
        end
        if (next_progress !== want.prog) begin
          $error("next_progress expected %0d actual %0d", want.prog, next_progress);
          failed = 1'b1;
        end
      end
      @(negedge clk);
    end
  end

  // Send one state beat after a random gap; the prediction is queued as
  // the beat is accepted.
  task automatic send_state(input vehicle_t s, input bit no_gap = 1'b0);
    advanced_t r;
    int gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= s.x; pos_y <= s.y; heading_in <= s.hdg; speed_in <= s.spd;
    progress_in <= s.prog; accel_cmd <= s.acc; turn_rate_cmd <= s.turn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_vehicle(s, r);
    pending_steps = {pending_steps, r};
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic write_reg(input logic idx, input logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == urk3_pkg::REG_TIME_STEP) step_dt = val;
    else speed_cap = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic vehicle_t random_state();
    vehicle_t s;
    s.x = $urandom;
    s.y = $urandom;
    s.hdg = 16'($urandom);
    s.spd = 16'($urandom);
    s.prog = $urandom;
    s.acc = 16'($urandom);
    s.turn = 16'($urandom);
    // Mostly legal headings, often moderate speeds; the rest is raw noise.
    if ($urandom_range(0, 3) != 0) s.hdg = 16'($urandom_range(0, 51471) - 25736);
    if ($urandom_range(0, 2) == 0) s.spd = 16'($urandom_range(0, 1200));
    if ($urandom_range(0, 9) == 0) s.x = $urandom_range(0, 1) ? 32'sh7FFF_FF00 : 32'sh8000_0100;
    if ($urandom_range(0, 9) == 0) s.prog = 32'hFFFF_F000 | $urandom_range(0, 4095);
    return s;
  endfunction

  task automatic test_directed_corners();
    vehicle_t s;
    s = '0;
    send_state(s);
    s.hdg = 16'sh7FFF; s.spd = 16'sh7FFF; s.acc = 16'sh7FFF; s.turn = 16'sh7FFF;
    send_state(s);
    s.hdg = 16'sh8000; s.spd = 16'sh8000; s.acc = 16'sh8000; s.turn = 16'sh8000;
    send_state(s);
    s = '0; s.hdg = 16'sd25735; s.spd = 16'sd512; send_state(s);
    s.hdg = -16'sd25736; send_state(s);
    s.hdg = 16'sd12868; send_state(s);
    s.hdg = -16'sd12869; send_state(s);
    s.spd = -16'sd300; s.acc = 16'sd2000; send_state(s);
    s.spd = 16'sd2000; s.acc = -16'sd50; send_state(s);
    s.x = 32'sh7FFF_FFFF; s.y = 32'sh8000_0000; s.hdg = 16'sd0; s.spd = 16'sd768;
    s.prog = 32'hFFFF_FFFF; send_state(s);
    s.hdg = 16'sd25735; s.x = 32'sh8000_0000; s.y = 32'sh7FFF_FFFF; send_state(s);
    s.hdg = 16'sd12868; s.turn = 16'sd25000; send_state(s, 1'b1);
    s.turn = -16'sd25000; send_state(s, 1'b1);
  endtask

  task automatic test_random_states(input int n);
    repeat (n) send_state(random_state());
  endtask

  task automatic test_zero_step();
    write_reg(urk3_pkg::REG_TIME_STEP, 16'd0);
    test_directed_corners();
    test_random_states(40);
  endtask

  task automatic test_zero_limit();
    write_reg(urk3_pkg::REG_TIME_STEP, 16'd6554);
    write_reg(urk3_pkg::REG_SPEED_LIMIT, 16'd0);
    test_random_states(60);
  endtask

  task automatic test_wide_settings();
    write_reg(urk3_pkg::REG_TIME_STEP, 16'hFFFF);
    write_reg(urk3_pkg::REG_SPEED_LIMIT, 16'hFFFF);
    test_directed_corners();
    test_random_states(150);
    write_reg(urk3_pkg::REG_TIME_STEP, 16'd1);
    test_random_states(60);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      write_reg(urk3_pkg::REG_TIME_STEP, 16'($urandom_range(1, 65535)));
      write_reg(urk3_pkg::REG_SPEED_LIMIT, 16'($urandom_range(0, 65535)));
      test_random_states(120);
    end
  endtask

  initial begin
    step_dt = 6554;
    speed_cap = 768;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_random_states(300);
    test_zero_step();
    test_zero_limit();
    test_wide_settings();
    test_random_settings();
    drain();
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/urk3_pkg.sv
hdl/urk3_cordic.sv
hdl/unicycle_rk3_state_step.sv
bench/unicycle_rk3_state_step_test.sv
